>>> design/tlik_pkg.sv
// Shared types, widths, status codes and the CORDIC angle table for the
// two-link inverse kinematics core. Depends on nothing.
package tlik_pkg;

  localparam int COORD_BITS        = 18;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int LEN_BITS          = 16;
  localparam int FRAC              = 16;
  localparam int QB                = FRAC + 1;
  localparam int WIDE = (2 * COORD_BITS + 1 > 2 * LEN_BITS + 2) ?
                        2 * COORD_BITS + 1 : 2 * LEN_BITS + 2;
  localparam int RW   = WIDE + FRAC;
  localparam int VW   = 2 * FRAC + 1;
  localparam int TW   = 2 * FRAC + 3;
  localparam int CW   = ((COORD_BITS > 2 * LEN_BITS + 2) ?
                         COORD_BITS : 2 * LEN_BITS + 2) + 3;
  localparam int ZW   = 26;
  localparam int IDXW = 2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_FAR  = 2'd1;
  localparam logic [1:0] STATUS_TOO_NEAR = 2'd2;
  localparam logic [1:0] STATUS_ZERO_LNK = 2'd3;

  localparam logic [IDXW-1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [IDXW-1:0] REG_SECOND_LINK = 2'd1;

  localparam logic [LEN_BITS-1:0] LINK_RESET = 16'd25600;

  typedef struct packed {
    logic [1:0]                   status;
    logic                         neg;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } side_t;

  // atan(2^-i) in degrees, 16 fraction bits.
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 26'sd2949120;  1: a = 26'sd1740967;  2: a = 26'sd919879;
      3: a = 26'sd466945;   4: a = 26'sd234379;   5: a = 26'sd117304;
      6: a = 26'sd58666;    7: a = 26'sd29335;    8: a = 26'sd14668;
      9: a = 26'sd7334;     10: a = 26'sd3667;    11: a = 26'sd1833;
      12: a = 26'sd917;     13: a = 26'sd458;     14: a = 26'sd229;
      15: a = 26'sd115;     16: a = 26'sd57;      17: a = 26'sd29;
      18: a = 26'sd14;      19: a = 26'sd7;       20: a = 26'sd4;
      21: a = 26'sd2;       22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> design/tlik_if.sv
// Valid/ready channel interfaces for target words and joint-angle words.
// Depends on tlik_pkg.
interface tlik_in_if;
  import tlik_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface tlik_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] shoulder_angle;
  logic [14:0]        elbow_angle;
  logic [1:0]         solve_status;
  modport source (output valid, shoulder_angle, elbow_angle, solve_status, input ready);
  modport sink   (input valid, shoulder_angle, elbow_angle, solve_status, output ready);
endinterface

>>> design/two_link_inverse_kinematics_core.sv
// Top level of the two-link inverse kinematics core.
// Depends on tlik_pkg, tlik_if, tlik_divider, tlik_isqrt and tlik_cordic.
//
// Accepts one target word per cycle and returns one joint-angle word per
// target, in order, through a squaring stage, a reach-check stage, a
// 17-stage quotient divider, a cosine-squaring stage, a 17-stage square
// root, a link-product stage, the CORDIC pipeline (one stage per
// iteration plus a quadrant stage) and the output register. The whole
// pipeline holds while a result waits at the output. Link lengths may
// only be written while no target is in flight.
module two_link_inverse_kinematics_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tlik_pkg::IDXW-1:0]      cfg_index,
  input  logic [tlik_pkg::LEN_BITS-1:0]  cfg_data,
  tlik_in_if.sink                        target,
  tlik_out_if.source                     result
);
  import tlik_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int LB    = LEN_BITS;
  localparam int D_XY  = 2 * QB + 2;
  localparam int SIDE  = D_XY + CORDIC_ITERATIONS + 1;
  localparam int TOTAL = D_XY + CORDIC_ITERATIONS + 4;

  logic [LB-1:0] l1, l2;
  logic          en;
  logic [TOTAL-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= LINK_RESET;
      l2 <= LINK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_LINK:  l1 <= cfg_data;
        REG_SECOND_LINK: l2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en           = !vld[TOTAL-1] || result.ready;
  assign target.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], target.valid};
    end
  end

  // Stage 1: squares.
  logic [CB-1:0]     ax, ay;
  logic [2*CB-1:0]   ax_sq, ay_sq;
  logic [2*LB-1:0]   l1_sq, l2_sq, l12;
  logic [LB:0]       lsum;
  logic [2*LB+1:0]   reach_c;

  assign ax      = target.target_x[CB-1] ? ~target.target_x + 1'b1 : target.target_x;
  assign ay      = target.target_y[CB-1] ? ~target.target_y + 1'b1 : target.target_y;
  assign ax_sq   = ax * ax;
  assign ay_sq   = ay * ay;
  assign l1_sq   = l1 * l1;
  assign l2_sq   = l2 * l2;
  assign l12     = l1 * l2;
  assign lsum    = {1'b0, l1} + {1'b0, l2};
  assign reach_c = lsum * lsum;

  logic signed [CB-1:0] x1, y1;
  logic [WIDE-1:0]      ax2, ay2, l1sq1, l2sq1, l121, reach1;
  logic                 zl1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= target.target_x;
      y1     <= target.target_y;
      ax2    <= WIDE'(ax_sq);
      ay2    <= WIDE'(ay_sq);
      l1sq1  <= WIDE'(l1_sq);
      l2sq1  <= WIDE'(l2_sq);
      l121   <= WIDE'(l12);
      reach1 <= WIDE'(reach_c);
      zl1    <= (l1 == '0) || (l2 == '0);
    end
  end

  // Stage 2: reach checks and the cosine numerator.
  logic [WIDE-1:0]        d2, sum_sq, den_c, mag_c;
  logic signed [WIDE:0]   num;
  logic [1:0]             st_c;

  assign d2     = ax2 + ay2;
  assign sum_sq = l1sq1 + l2sq1;
  assign den_c  = l121 << 1;
  assign num    = $signed({1'b0, d2}) - $signed({1'b0, sum_sq});
  assign mag_c  = num[WIDE] ? WIDE'(-num) : num[WIDE-1:0];

  always_comb begin
    if (zl1) st_c = STATUS_ZERO_LNK;
    else if (d2 > reach1) st_c = STATUS_TOO_FAR;
    else if (num[WIDE] && (mag_c > den_c)) st_c = STATUS_TOO_NEAR;
    else st_c = STATUS_OK;
  end

  logic [WIDE-1:0] mag2, den2;
  side_t           side_p [0:SIDE];

  always_ff @(posedge clk) begin
    if (en) begin
      mag2             <= mag_c;
      den2             <= den_c;
      side_p[0].status <= st_c;
      side_p[0].neg    <= num[WIDE];
      side_p[0].x      <= x1;
      side_p[0].y      <= y1;
    end
  end

  for (genvar k = 0; k < SIDE; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side_p[k+1] <= side_p[k];
    end
  end

  logic [QB-1:0] quot;
  tlik_divider u_div (.clk, .en, .mag(mag2), .den(den2), .quot);

  // Stage 3: signed cosine and its square.
  logic signed [QB:0]     c_c;
  logic signed [2*QB+1:0] csq_c;
  logic signed [QB:0]     c_p [0:QB];
  logic [VW-1:0]          csq3, v;

  assign c_c   = side_p[QB].neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign csq_c = c_c * c_c;

  always_ff @(posedge clk) begin
    if (en) begin
      c_p[0] <= c_c;
      csq3   <= csq_c[VW-1:0];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_cdly
    always_ff @(posedge clk) begin
      if (en) c_p[k+1] <= c_p[k];
    end
  end

  assign v = (VW'(1) << (2 * FRAC)) - csq3;

  logic [QB-1:0] s_root;
  tlik_isqrt u_sqrt (.clk, .en, .v, .root(s_root));

  // Stage 4: link products feeding the second atan2.
  logic signed [LB+QB+1:0] l2c;
  logic [LB+QB-1:0]        l2s;
  logic signed [CW-1:0]    k1_4, k2_4, c4, s4, x4, y4;

  assign l2c = $signed({1'b0, l2}) * c_p[QB];
  assign l2s = l2 * s_root;

  always_ff @(posedge clk) begin
    if (en) begin
      k1_4 <= $signed(CW'({l1, {FRAC{1'b0}}})) + CW'(l2c);
      k2_4 <= $signed(CW'(l2s));
      c4   <= CW'(c_p[QB]);
      s4   <= $signed(CW'(s_root));
      x4   <= CW'(side_p[D_XY-1].x);
      y4   <= CW'(side_p[D_XY-1].y);
    end
  end

  logic signed [ZW-1:0] a_yx, a_sc, a_k;
  tlik_cordic u_cord_yx (.clk, .en, .vx(x4),   .vy(y4),   .angle(a_yx));
  tlik_cordic u_cord_sc (.clk, .en, .vx(c4),   .vy(s4),   .angle(a_sc));
  tlik_cordic u_cord_k  (.clk, .en, .vx(k1_4), .vy(k2_4), .angle(a_k));

  // Output stage: round to 7 fraction bits and clamp.
  localparam logic signed [ZW-1:0] SH_MIN = -26'sd46080;
  localparam logic signed [ZW-1:0] ANG_MAX = 26'sd23040;

  logic signed [ZW-1:0] th1, sum1, sum2, r1, r2, q1, q2;
  logic [1:0]           st_o;

  assign th1  = a_yx - a_k;
  assign sum1 = th1 + 26'sd256;
  assign sum2 = a_sc + 26'sd256;
  assign r1   = sum1 >>> 9;
  assign r2   = sum2 >>> 9;
  assign q1   = (r1 < SH_MIN) ? SH_MIN : ((r1 > ANG_MAX) ? ANG_MAX : r1);
  assign q2   = (r2 < 0) ? '0 : ((r2 > ANG_MAX) ? ANG_MAX : r2);
  assign st_o = side_p[SIDE].status;

  always_ff @(posedge clk) begin
    if (en) begin
      result.solve_status   <= st_o;
      result.shoulder_angle <= (st_o == STATUS_OK) ? q1[16:0] : '0;
      result.elbow_angle    <= (st_o == STATUS_OK) ? q2[14:0] : '0;
    end
  end

  assign result.valid = vld[TOTAL-1];

  // A failed solve never carries angles.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.solve_status != STATUS_OK) |->
      (result.shoulder_angle == '0) && (result.elbow_angle == '0))
    else $error("angles present on a failed solve");

  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.elbow_angle <= 15'd23040)
    else $error("elbow angle out of range");

  // A held pipeline must not gain or drop words.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule

>>> design/tlik_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for the cosine.
// Depends on tlik_pkg.
module tlik_divider (
  input  logic                   clk,
  input  logic                   en,
  input  logic [tlik_pkg::WIDE-1:0] mag,
  input  logic [tlik_pkg::WIDE-1:0] den,
  output logic [tlik_pkg::QB-1:0]   quot
);
  import tlik_pkg::*;

  logic [RW-1:0]   rem   [0:QB];
  logic [WIDE-1:0] den_p [0:QB];
  logic [QB-1:0]   q_p   [0:QB];

  assign rem[0]   = {mag, {FRAC{1'b0}}};
  assign den_p[0] = den;
  assign q_p[0]   = '0;

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [RW-1:0] trial;
    logic          fits;
    assign trial = RW'(den_p[j]) << B;
    assign fits  = rem[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]   <= fits ? rem[j] - trial : rem[j];
        den_p[j+1] <= den_p[j];
        q_p[j+1]   <= {q_p[j][QB-2:0], fits};
      end
    end
  end

  assign quot = q_p[QB];
endmodule

>>> design/tlik_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on tlik_pkg.
module tlik_isqrt (
  input  logic                  clk,
  input  logic                  en,
  input  logic [tlik_pkg::VW-1:0] v,
  output logic [tlik_pkg::QB-1:0] root
);
  import tlik_pkg::*;

  logic [TW-1:0] rem [0:QB];
  logic [QB-1:0] r_p [0:QB];

  assign rem[0] = TW'(v);
  assign r_p[0] = '0;

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [TW-1:0] trial;
    logic          fits;
    assign trial = (TW'(r_p[j]) << (B + 1)) + (TW'(1) << (2 * B));
    assign fits  = rem[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= fits ? rem[j] - trial : rem[j];
        r_p[j+1] <= fits ? (r_p[j] | (QB'(1) << B)) : r_p[j];
      end
    end
  end

  assign root = r_p[QB];
endmodule

>>> design/tlik_cordic.sv
// Pipelined CORDIC vectoring unit giving atan2 in degrees, 16 fraction bits.
// Depends on tlik_pkg for widths and the angle table.
module tlik_cordic (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [tlik_pkg::CW-1:0] vx,
  input  logic signed [tlik_pkg::CW-1:0] vy,
  output logic signed [tlik_pkg::ZW-1:0] angle
);
  import tlik_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic signed [CW-1:0] px [0:N];
  logic signed [CW-1:0] py [0:N];
  logic signed [ZW-1:0] pz [0:N];
  logic                 zr [0:N];

  // Left half-plane vectors are turned by a quarter turn before the loop.
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (vx == '0) && (vy == '0);
      if (vx < 0) begin
        if (vy >= 0) begin
          px[0] <= vy;
          py[0] <= -vx;
          pz[0] <= ZW'(90 * 65536);
        end else begin
          px[0] <= -vy;
          py[0] <= vx;
          pz[0] <= -ZW'(90 * 65536);
        end
      end else begin
        px[0] <= vx;
        py[0] <= vy;
        pz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = py[i] >>> i;
    assign dy = px[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (py[i] > 0) begin
          px[i+1] <= px[i] + dx;
          py[i+1] <= py[i] - dy;
          pz[i+1] <= pz[i] + atan_q16(i);
        end else begin
          px[i+1] <= px[i] - dx;
          py[i+1] <= py[i] + dy;
          pz[i+1] <= pz[i] - atan_q16(i);
        end
      end
    end
  end

  assign angle = zr[N] ? '0 : pz[N];
endmodule

>>> tb/two_link_inverse_kinematics_core_test.sv
// Self-checking testbench for the two-link inverse kinematics core.
// Depends on tlik_pkg, tlik_if and two_link_inverse_kinematics_core.
`timescale 1ns / 100ps

module two_link_inverse_kinematics_core_test;
  import tlik_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic signed [16:0] shoulder;
    logic [14:0]        elbow;
    logic [1:0]         status;
  } angles_t;

  localparam longint ARCTAN_DEG[16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDXW-1:0] cfg_index;
  logic [LEN_BITS-1:0] cfg_data;

  tlik_in_if  target_ch ();
  tlik_out_if result_ch ();

  two_link_inverse_kinematics_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .target(target_ch.sink), .result(result_ch.source)
  );

  logic [LEN_BITS-1:0] link1, link2;
  angles_t pending_angles[$];
  int failures;
  int idle_cycles;
  bit long_hold_req;
  bit zero_gap_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint isqrt_floor(longint unsigned v);
    longint unsigned r, bits;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= r + bits) begin
        v -= r + bits;
        r = (r >> 1) + bits;
      end else begin
        r >>= 1;
      end
      bits >>= 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC in degrees with 16 fraction bits; left half plane is
  // pre-rotated by a quarter turn.
  function automatic longint atan2_deg(longint vy, longint vx);
    longint px, py, z, t, dx, dy;
    px = vx;
    py = vy;
    z = 0;
    if (px == 0 && py == 0) return 0;
    if (px < 0) begin
      t = px;
      if (py >= 0) begin
        px = py; py = -t; z = 90 * 65536;
      end else begin
        px = -py; py = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py > 0) begin
        px += dx; py -= dy; z += ARCTAN_DEG[i];
      end else begin
        px -= dx; py += dy; z -= ARCTAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_q7(longint a, longint lo, longint hi);
    longint q;
    q = (a + 256) >>> 9;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic angles_t solve_joints(logic signed [COORD_BITS-1:0] tx,
                                           logic signed [COORD_BITS-1:0] ty);
    angles_t r;
    longint x, y, l1, l2, d2, reach, sum_sq, den, num, mag, c, s, k1, k2, th1, th2;
    x = tx;
    y = ty;
    l1 = link1;
    l2 = link2;
    r.shoulder = '0;
    r.elbow = '0;
    r.status = STATUS_OK;
    d2 = x * x + y * y;
    reach = (l1 + l2) * (l1 + l2);
    sum_sq = l1 * l1 + l2 * l2;
    den = 2 * l1 * l2;
    if (l1 == 0 || l2 == 0) begin
      r.status = STATUS_ZERO_LNK;
    end else if (d2 > reach) begin
      r.status = STATUS_TOO_FAR;
    end else begin
      num = d2 - sum_sq;
      if (num < 0 && -num > den) begin
        r.status = STATUS_TOO_NEAR;
      end else begin
        mag = num < 0 ? -num : num;
        c = (mag << 16) / den;
        if (num < 0) c = -c;
        s = isqrt_floor(64'd4294967296 - c * c);
        k1 = l1 * 65536 + l2 * c;
        k2 = l2 * s;
        th2 = atan2_deg(s, c);
        th1 = atan2_deg(y, x) - atan2_deg(k2, k1);
        r.shoulder = 17'(round_q7(th1, -46080, 23040));
        r.elbow = 15'(round_q7(th2, 0, 23040));
      end
    end
    return r;
  endfunction

  function automatic int draw_gap();
    if (zero_gap_mode) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Called just after an acceptance or at idle; valid stays high between
  // back-to-back words.
  task automatic send_target(logic signed [COORD_BITS-1:0] tx,
                             logic signed [COORD_BITS-1:0] ty);
    int gap;
    angles_t exp_angles;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      target_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    target_ch.valid <= 1'b1;
    target_ch.target_x <= tx;
    target_ch.target_y <= ty;
    exp_angles = solve_joints(tx, ty);
    do @(posedge clk); while (!target_ch.ready);
    pending_angles.push_back(exp_angles);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    target_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_link(logic [IDXW-1:0] idx, logic [LEN_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIRST_LINK) link1 = value;
    else link2 = value;
  endtask

  task automatic set_links(logic [LEN_BITS-1:0] a, logic [LEN_BITS-1:0] b);
    wait_drained();
    write_link(REG_FIRST_LINK, a);
    write_link(REG_SECOND_LINK, b);
  endtask

  function automatic logic signed [COORD_BITS-1:0] clip_coord(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return COORD_BITS'(v);
  endfunction

  // Mostly targets in a square just around the links' reach, the rest anywhere in the field range.
  task automatic send_random_targets(int count);
    longint span, x, y;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        span = longint'(link1) + longint'(link2) + 2;
        x = longint'($urandom_range(0, 2 * span)) - span;
        y = longint'($urandom_range(0, 2 * span)) - span;
        send_target(clip_coord(x), clip_coord(y));
      end else begin
        send_target(COORD_BITS'($urandom), COORD_BITS'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_target(0, 0);
    send_target(18'sd131071, 18'sd131071);
    send_target(-18'sd131072, -18'sd131072);
    send_target(-18'sd131072, 18'sd131071);
    send_target(18'sd51200, 0);
    send_target(0, 18'sd51200);
    send_target(-18'sd51200, 0);
    send_target(0, -18'sd51200);
    send_target(18'sd51201, 0);
    send_target(-18'sd25600, -18'sd100);
    send_target(18'sd36203, 18'sd36203);
    set_links(16'd25600, 16'd12800);
    send_target(0, 0);
    send_target(18'sd12799, 0);
    send_target(18'sd12800, 0);
    send_target(18'sd38400, 0);
    send_target(-18'sd20000, 18'sd100);
    set_links(16'd0, 16'd25600);
    send_target(18'sd100, 18'sd100);
    set_links(16'd25600, 16'd0);
    send_target(18'sd100, 18'sd100);
    set_links(16'd65535, 16'd65535);
    send_target(18'sd131071, 0);
    send_target(0, 0);
    send_target(-18'sd131072, -18'sd1);
  endtask

  task automatic test_random_settings();
    set_links(16'd25600, 16'd25600);
    send_random_targets(100);
    set_links(16'd1, 16'd1);
    send_random_targets(60);
    set_links(16'd65535, 16'd1);
    send_random_targets(60);
    set_links(16'd100, 16'd30000);
    send_random_targets(60);
    set_links(16'($urandom), 16'($urandom));
    send_random_targets(80);
    set_links(16'd65535, 16'd65535);
    send_random_targets(60);
  endtask

  task automatic test_back_to_back();
    set_links(16'd20000, 16'd30000);
    zero_gap_mode = 1'b1;
    send_random_targets(80);
    zero_gap_mode = 1'b0;
  endtask

  task automatic test_output_stall();
    set_links(16'd25600, 16'd25600);
    long_hold_req = 1'b1;
    send_random_targets(120);
    wait_drained();
  endtask

  // Receiver: random stalls per word, with one long hold-off on request.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = zero_gap_mode ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    angles_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected word: shoulder %0d elbow %0d status %0d", $time,
                 result_ch.shoulder_angle, result_ch.elbow_angle, result_ch.solve_status);
        failures++;
      end else begin
        e = pending_angles.pop_front();
        if (result_ch.solve_status !== e.status) begin
          $display("%0t: solve_status expected %0d actual %0d", $time, e.status,
                   result_ch.solve_status);
          failures++;
        end
        if (result_ch.shoulder_angle !== e.shoulder) begin
          $display("%0t: shoulder_angle expected %0d actual %0d", $time, e.shoulder,
                   result_ch.shoulder_angle);
          failures++;
        end
        if (result_ch.elbow_angle !== e.elbow) begin
          $display("%0t: elbow_angle expected %0d actual %0d", $time, e.elbow,
                   result_ch.elbow_angle);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (target_ch.valid && target_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_link_inverse_kinematics_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    target_ch.valid = 1'b0;
    target_ch.target_x = '0;
    target_ch.target_y = '0;
    link1 = LINK_RESET;
    link2 = LINK_RESET;
    failures = 0;
    idle_cycles = 0;
    long_hold_req = 1'b0;
    zero_gap_mode = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_settings();
    test_back_to_back();
    test_output_stall();
    wait_drained();
    if (failures == 0) begin
      $display("two_link_inverse_kinematics_core verification clean");
    end else begin
      $display("two_link_inverse_kinematics_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tlik_pkg.sv
design/tlik_if.sv
design/tlik_divider.sv
design/tlik_isqrt.sv
design/tlik_cordic.sv
design/two_link_inverse_kinematics_core.sv
tb/two_link_inverse_kinematics_core_test.sv
